// ----- hdl/five_way_key_press_qualifier_core_defines.svh -----
// ----------------------------------------------------------------------------
// key qualifier assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef FIVE_WAY_KEY_PRESS_QUALIFIER_CORE_DEFINES_SVH
`define FIVE_WAY_KEY_PRESS_QUALIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define KPQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/kpq_pkg.sv -----
// ----------------------------------------------------------------------------
// kpq_pkg
// types and constants of the five-way key press qualifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kpq_pkg;

  localparam int AdcBits   = 12;
  localparam int NumLevels = 5;
  localparam int AdcWindow = 3;
  localparam int InWidth   = 48;
  localparam int OutWidth  = 8;
  localparam int AddrWidth = 5;

  localparam logic [2:0] KeyNone = 3'd7;

  localparam logic kind_sample = 1'b0;
  localparam logic kind_read   = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [2:0] RegAnalogMode = 3'd0;
  localparam logic [2:0] RegLevelUp    = 3'd1;
  localparam logic [2:0] RegLevelDown  = 3'd2;
  localparam logic [2:0] RegLevelLeft  = 3'd3;
  localparam logic [2:0] RegLevelRight = 3'd4;
  localparam logic [2:0] RegLevelEnter = 3'd5;
  localparam logic [2:0] RegHoldoff    = 3'd6;
  localparam logic [2:0] RegLongPress  = 3'd7;

  localparam logic [15:0] HoldoffReset   = 16'd500;
  localparam logic [15:0] LongPressReset = 16'd1000;

  typedef struct packed {
    logic       long_pressed;
    logic [2:0] key_value;
  } result_t;

endpackage

// ----- hdl/five_way_key_press_qualifier_core.sv -----
// ----------------------------------------------------------------------------
// five_way_key_press_qualifier_core
// five-way key qualifier: press latch, long-press and release hold-off
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tuser kind, tdata pin/adc/now_ms
//  m_*      | out | m_tvalid/m_tready  | tdata key_value, long_pressed
//  apb      | in  | psel/penable/pready| eight config registers at 4*i
//
//  one request per cycle while s_tready is high; result registered, in skid if m_* stalls
//  key state is updated at the accepting edge, so the next request sees it
//  a two-entry output (register plus skid) keeps s_tready high while one
//  result waits; s_tready drops only once both entries are full
//  rst is synchronous: key state, handshake flags and registers to defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "five_way_key_press_qualifier_core_defines.svh"

module five_way_key_press_qualifier_core (
  input  logic                          clk,
  input  logic                          rst,
  // input requests
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kpq_pkg::InWidth-1:0]   s_tdata,   // [2:0] pin_code, [14:3] adc_sample,
                                                   // [46:15] now_ms, [47] zero
  input  logic                          s_tuser,   // [0] kind
  // results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kpq_pkg::OutWidth-1:0]  m_tdata,   // [2:0] key_value, [3] long_pressed,
                                                   // [7:4] zero
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kpq_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                       analog_mode;
  logic [kpq_pkg::AdcBits-1:0] level [kpq_pkg::NumLevels];
  logic [15:0]                release_holdoff_ms;
  logic [15:0]                long_press_ms;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      analog_mode        <= 1'b0;
      for (int i = 0; i < kpq_pkg::NumLevels; i++) begin
        level[i] <= '0;
      end
      release_holdoff_ms <= kpq_pkg::HoldoffReset;
      long_press_ms      <= kpq_pkg::LongPressReset;
    end else if (cfg_write) begin
      case (cfg_index)
        kpq_pkg::RegAnalogMode: analog_mode        <= pwdata[0];
        kpq_pkg::RegLevelUp:    level[0]           <= pwdata[kpq_pkg::AdcBits-1:0];
        kpq_pkg::RegLevelDown:  level[1]           <= pwdata[kpq_pkg::AdcBits-1:0];
        kpq_pkg::RegLevelLeft:  level[2]           <= pwdata[kpq_pkg::AdcBits-1:0];
        kpq_pkg::RegLevelRight: level[3]           <= pwdata[kpq_pkg::AdcBits-1:0];
        kpq_pkg::RegLevelEnter: level[4]           <= pwdata[kpq_pkg::AdcBits-1:0];
        kpq_pkg::RegHoldoff:    release_holdoff_ms <= pwdata[15:0];
        kpq_pkg::RegLongPress:  long_press_ms      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    prdata = '0;
    case (cfg_index)
      kpq_pkg::RegAnalogMode: prdata = {31'd0, analog_mode};
      kpq_pkg::RegLevelUp:    prdata = {{(32-kpq_pkg::AdcBits){1'b0}}, level[0]};
      kpq_pkg::RegLevelDown:  prdata = {{(32-kpq_pkg::AdcBits){1'b0}}, level[1]};
      kpq_pkg::RegLevelLeft:  prdata = {{(32-kpq_pkg::AdcBits){1'b0}}, level[2]};
      kpq_pkg::RegLevelRight: prdata = {{(32-kpq_pkg::AdcBits){1'b0}}, level[3]};
      kpq_pkg::RegLevelEnter: prdata = {{(32-kpq_pkg::AdcBits){1'b0}}, level[4]};
      kpq_pkg::RegHoldoff:    prdata = {16'd0, release_holdoff_ms};
      kpq_pkg::RegLongPress:  prdata = {16'd0, long_press_ms};
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // request fields
  // --------------------------------------------------------------------------
  logic                        kind;
  logic [2:0]                  pin_code;
  logic [kpq_pkg::AdcBits-1:0] adc_sample;
  logic [31:0]                 now_ms;

  assign kind       = s_tuser;
  assign pin_code   = s_tdata[2:0];
  assign adc_sample = s_tdata[14:3];
  assign now_ms     = s_tdata[46:15];

  // --------------------------------------------------------------------------
  // analog classification: window of +/-2 around each level, up has priority
  // --------------------------------------------------------------------------
  logic signed [kpq_pkg::AdcBits:0] level_diff [kpq_pkg::NumLevels];
  logic [kpq_pkg::NumLevels-1:0]    level_hit;
  logic [2:0]                       analog_key;
  logic [2:0]                       cur_key;

  always_comb begin
    for (int i = 0; i < kpq_pkg::NumLevels; i++) begin
      level_diff[i] = $signed({1'b0, adc_sample}) - $signed({1'b0, level[i]});
      level_hit[i]  = (level_diff[i] < kpq_pkg::AdcWindow) &&
                      (level_diff[i] > -kpq_pkg::AdcWindow);
    end
    analog_key = kpq_pkg::KeyNone;
    for (int i = kpq_pkg::NumLevels - 1; i >= 0; i--) begin
      if (level_hit[i]) begin
        analog_key = 3'(i);
      end
    end
  end

  assign cur_key = analog_mode ? analog_key : pin_code;

  // --------------------------------------------------------------------------
  // key state
  // --------------------------------------------------------------------------
  logic        press_active, press_active_next;
  logic        long_flag,    long_flag_next;
  logic [2:0]  held_key,     held_key_next;
  logic [2:0]  reported_key, reported_key_next;
  logic [31:0] press_start_ms, press_start_ms_next;
  logic [31:0] elapsed;
  kpq_pkg::result_t result;

  logic accept_in;
  logic skid_valid;

  assign s_tready  = ~skid_valid;
  assign accept_in = s_tvalid & s_tready;
  assign elapsed   = now_ms - press_start_ms;   // wraps modulo 2^32

  always_comb begin
    press_active_next   = press_active;
    long_flag_next      = long_flag;
    held_key_next       = held_key;
    reported_key_next   = reported_key;
    press_start_ms_next = press_start_ms;
    result.key_value    = reported_key;
    result.long_pressed = long_flag;

    if (kind == kpq_pkg::kind_read) begin
      // report first, then clear if a key was recorded
      if (reported_key != kpq_pkg::KeyNone) begin
        press_active_next = 1'b0;
        long_flag_next    = 1'b0;
        reported_key_next = kpq_pkg::KeyNone;
      end
    end else begin
      if (press_active) begin
        if (cur_key == kpq_pkg::KeyNone) begin
          // release
          if (long_flag) begin
            press_active_next = 1'b0;
            long_flag_next    = 1'b0;
            reported_key_next = kpq_pkg::KeyNone;
          end else begin
            reported_key_next = held_key;
            if (elapsed > {16'd0, release_holdoff_ms}) begin
              press_active_next = 1'b0;
            end
          end
        end else if (elapsed > {16'd0, long_press_ms}) begin
          long_flag_next = 1'b1;
        end
      end else begin
        // idle: latch the first press
        held_key_next = cur_key;
        if (cur_key != kpq_pkg::KeyNone) begin
          press_active_next   = 1'b1;
          long_flag_next      = 1'b0;
          press_start_ms_next = now_ms;
        end
      end
      result.key_value    = reported_key_next;
      result.long_pressed = long_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_active   <= 1'b0;
      long_flag      <= 1'b0;
      held_key       <= kpq_pkg::KeyNone;
      reported_key   <= kpq_pkg::KeyNone;
      press_start_ms <= '0;
    end else if (accept_in) begin
      press_active   <= press_active_next;
      long_flag      <= long_flag_next;
      held_key       <= held_key_next;
      reported_key   <= reported_key_next;
      press_start_ms <= press_start_ms_next;
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid entry
  // --------------------------------------------------------------------------
  kpq_pkg::result_t out_result;
  kpq_pkg::result_t skid_result;
  logic             out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept_in;
      end
    end else if (accept_in) begin
      // output stalled: park the new result
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_result <= skid_result;
      end else if (accept_in) begin
        out_result <= result;
      end
    end else if (accept_in) begin
      skid_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(kpq_pkg::OutWidth-4){1'b0}}, out_result};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `KPQ_ASSERT_IMPLY(a_long_needs_press, long_flag, press_active, "long flag without a press")
  `KPQ_ASSERT_IMPLY(a_skid_behind_out, skid_valid, out_valid, "skid entry ahead of output")
  `KPQ_ASSERT_NEXT(a_accept_gives_result, accept_in, out_valid, "accepted request lost")

endmodule
